[rtl/dle_stx_etx_deframer_core_macros.svh]
// Assertion macros shared by the DLE/STX/ETX deframer RTL.
`ifndef DLE_STX_ETX_DEFRAMER_CORE_MACROS_SVH
`define DLE_STX_ETX_DEFRAMER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every rising edge out of reset.
`define DSED_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define DSED_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`else

`define DSED_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DSED_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/dsed_pkg.sv]
// Types, codes and constants for the DLE/STX/ETX deframer.
`default_nettype none

package dsed_pkg;

    localparam int DEF_MAX_FRAME_BYTES = 256;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 9;
    localparam int CFG_W  = 9;

    localparam logic [CFG_W-1:0] MAX_LENGTH_RST = 9'd256;

    localparam logic [BYTE_W-1:0] SYM_DLE = 8'h10;
    localparam logic [BYTE_W-1:0] SYM_STX = 8'h02;
    localparam logic [BYTE_W-1:0] SYM_ETX = 8'h03;

    typedef enum logic [1:0] {
        MODE_HUNT      = 2'd0,
        MODE_HUNT_DLE  = 2'd1,
        MODE_FRAME     = 2'd2,
        MODE_FRAME_ESC = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_DATA     = 3'd1,
        EV_END_OK   = 3'd2,
        EV_BAD_ESC  = 3'd3,
        EV_OVERFLOW = 3'd4
    } ev_t;

    // One received byte held between the input and decode stages.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    // One decode result.
    typedef struct packed {
        ev_t               event_res;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] byte_index;
        logic [LEN_W-1:0]  frame_length;
    } res_t;

endpackage

`default_nettype wire

[rtl/dsed_in_stage.sv]
// Input register stage of the deframer: captures one received byte per transfer.
`default_nettype none

module dsed_in_stage
    import dsed_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic              advance,
    output logic                   in_stall,
    output item_t                  item
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // Hold while the held byte cannot move on to the result register.
    assign in_stall   = valid_reg && !advance;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign item.valid   = valid_reg;
    assign item.rx_byte = byte_reg;

endmodule

`default_nettype wire

[rtl/dsed_decode.sv]
// Framing state machine and decoded byte counter of the deframer.
`default_nettype none

module dsed_decode
    import dsed_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic [CFG_W-1:0] max_length,
    output res_t                  res
);

    localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int WIDE_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    mode_t             mode_reg;
    mode_t             mode_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic [WIDE_W-1:0] count_wide;
    logic [WIDE_W-1:0] cfg_wide;
    logic [WIDE_W-1:0] limit;
    logic              at_limit;
    logic              is_dle;
    logic              is_stx;
    logic              is_etx;

    assign is_dle = (rx_byte == SYM_DLE);
    assign is_stx = (rx_byte == SYM_STX);
    assign is_etx = (rx_byte == SYM_ETX);

    // Clamp the limit to 1..MAX_FRAME_BYTES.
    assign cfg_wide   = WIDE_W'(max_length);
    assign count_wide = WIDE_W'(count_reg);
    always_comb
    begin
        if (cfg_wide == '0)
        begin
            limit = WIDE_W'(1);
        end
        else if (cfg_wide > WIDE_W'(MAX_FRAME_BYTES))
        begin
            limit = WIDE_W'(MAX_FRAME_BYTES);
        end
        else
        begin
            limit = cfg_wide;
        end
    end
    assign at_limit = (count_wide >= limit);

    // Next state and counter.
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        unique case (mode_reg)
            MODE_HUNT:
            begin
                if (is_dle)
                begin
                    mode_next = MODE_HUNT_DLE;
                end
            end
            MODE_HUNT_DLE:
            begin
                if (is_stx)
                begin
                    mode_next  = MODE_FRAME;
                    count_next = '0;
                end
                else if (!is_dle)
                begin
                    mode_next = MODE_HUNT;
                end
            end
            MODE_FRAME:
            begin
                if (is_dle)
                begin
                    mode_next = MODE_FRAME_ESC;
                end
                else if (at_limit)
                begin
                    mode_next = MODE_HUNT;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_FRAME_ESC:
            begin
                if (is_dle && !at_limit)
                begin
                    mode_next  = MODE_FRAME;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    mode_next = MODE_HUNT;
                end
            end
        endcase
    end

    // Result for the byte in hand.
    always_comb
    begin
        res.event_res    = EV_NONE;
        res.data_byte    = '0;
        res.byte_index   = '0;
        res.frame_length = '0;
        unique case (mode_reg)
            MODE_HUNT, MODE_HUNT_DLE:
            begin
                res.event_res = EV_NONE;
            end
            MODE_FRAME:
            begin
                if (!is_dle)
                begin
                    if (at_limit)
                    begin
                        res.event_res    = EV_OVERFLOW;
                        res.frame_length = count_wide[LEN_W-1:0];
                    end
                    else
                    begin
                        res.event_res  = EV_DATA;
                        res.data_byte  = rx_byte;
                        res.byte_index = count_wide[BYTE_W-1:0];
                    end
                end
            end
            MODE_FRAME_ESC:
            begin
                if (is_dle)
                begin
                    if (at_limit)
                    begin
                        res.event_res    = EV_OVERFLOW;
                        res.frame_length = count_wide[LEN_W-1:0];
                    end
                    else
                    begin
                        res.event_res  = EV_DATA;
                        res.data_byte  = rx_byte;
                        res.byte_index = count_wide[BYTE_W-1:0];
                    end
                end
                else if (is_etx)
                begin
                    res.event_res    = EV_END_OK;
                    res.frame_length = count_wide[LEN_W-1:0];
                end
                else
                begin
                    res.event_res    = EV_BAD_ESC;
                    res.frame_length = count_wide[LEN_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_HUNT;
            count_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/dsed_out_stage.sv]
// Result register of the deframer: holds one result until its transfer.
`default_nettype none

module dsed_out_stage
    import dsed_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load_valid,
    input  res_t      res_in,
    input  wire logic out_stall,
    output logic      advance,
    output logic      out_valid,
    output res_t      res_out
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    // The register can take a new result when empty or when its result leaves.
    assign advance    = !valid_reg || !out_stall;
    assign valid_next = advance ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_valid)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

`default_nettype wire

[rtl/dle_stx_etx_deframer_core.sv]
// A byte enters the input register; its result then goes to the result register.
// Takes one byte per cycle unless the result side stalls; the state updates once per byte.
// A byte waits in the input register only while the result register is stalled.
// Reset (rst_n low, asynchronous): hunting with no DLE seen, count zero, max_length 256,
// both pipeline registers empty.
`default_nettype none

`include "dle_stx_etx_deframer_core_macros.svh"

module dle_stx_etx_deframer_core
    import dsed_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // Received byte channel.
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] rx_byte,

    // Result channel.
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [2:0]             event_res,
    output logic [BYTE_W-1:0]      data_byte,
    output logic [BYTE_W-1:0]      byte_index,
    output logic [LEN_W-1:0]       frame_length,

    // Length limit write channel.
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  max_length
);

    item_t            item;
    res_t             dec_res;
    res_t             out_res;
    logic             advance;
    logic             step;
    logic [CFG_W-1:0] max_length_reg;

    // Length limit register; the port takes a write every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_length_reg <= max_length;
        end
    end

    // Input register: capture the received byte on its transfer.
    dsed_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .rx_byte  (rx_byte),
        .advance  (advance),
        .in_stall (in_stall),
        .item     (item)
    );

    // Advance the framing state exactly when the held byte moves into the
    // result register, so each byte updates the state once.
    assign step = item.valid && advance;

    dsed_decode #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_byte    (item.rx_byte),
        .max_length (max_length_reg),
        .res        (dec_res)
    );

    // Result register: every byte yields one result, event zero included.
    dsed_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (item.valid),
        .res_in     (dec_res),
        .out_stall  (out_stall),
        .advance    (advance),
        .out_valid  (out_valid),
        .res_out    (out_res)
    );

    assign event_res    = out_res.event_res;
    assign data_byte    = out_res.data_byte;
    assign byte_index   = out_res.byte_index;
    assign frame_length = out_res.frame_length;

    // The input side is held back only by a stalled, full result register.
    `DSED_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // A held byte moves into an empty result register on the next edge.
    `DSED_ASSERT_NXT(a_hold_moves, clk, rst_n, item.valid && !out_valid, out_valid)

    // A result without an event carries all-zero fields.
    `DSED_ASSERT_IMP(a_idle_zero, clk, rst_n, out_valid && (event_res == EV_NONE),
        (data_byte == '0) && (byte_index == '0) && (frame_length == '0))

endmodule

`default_nettype wire

[sim/tb_dle_stx_etx_deframer_core.sv]
// Testbench for the DLE/STX/ETX deframer: directed table plus random framed traffic.
`timescale 1ns / 100ps

module tb_dle_stx_etx_deframer_core
    import dsed_pkg::*;
();

    localparam int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES;
    localparam int IDLE_PCT        = 13;
    // Register stages in the block: the input register and the result register.
    localparam int PIPE_CYCLES     = 2;

    typedef enum logic { ROW_BYTE, ROW_CFG } row_kind_t;

    // One line of the directed table: a received byte or a length limit write.
    typedef struct {
        row_kind_t  kind;
        logic [8:0] value;
        bit         typed;
        res_t       want;
    } stim_row_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             in_valid     = 1'b0;
    logic             in_stall;
    logic [7:0]       rx_byte      = 8'h00;
    logic             out_valid;
    logic             out_stall    = 1'b0;
    logic [2:0]       event_res;
    logic [7:0]       data_byte;
    logic [7:0]       byte_index;
    logic [LEN_W-1:0] frame_length;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] max_length   = '0;

    // Shadow copy of the framing state, kept in step with every accepted byte.
    mode_t            frame_mode   = MODE_HUNT;
    logic [8:0]       frame_count  = '0;
    logic [8:0]       length_cap   = MAX_LENGTH_RST;

    res_t             pending_events[$];
    stim_row_t        stim_rows[$];
    res_t             head_event;
    int               bytes_sent   = 0;
    int               error_count  = 0;
    bit               quiet_run    = 1'b0;

    dle_stx_etx_deframer_core #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_res   (event_res),
        .data_byte   (data_byte),
        .byte_index  (byte_index),
        .frame_length(frame_length),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .max_length  (max_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Effective frame limit: zero acts as one, anything past the build size is clamped.
    function automatic logic [8:0] cap_limit();
        if (length_cap == 9'd0)
            return 9'd1;
        if (length_cap > MAX_FRAME_BYTES)
            return 9'(MAX_FRAME_BYTES);
        return length_cap;
    endfunction

    // Store one decoded byte, or flag an overflow when the frame is already full.
    function automatic res_t store_data(input logic [7:0] b);
        res_t r;
        r = '0;
        if (frame_count >= cap_limit())
        begin
            r.event_res    = EV_OVERFLOW;
            r.frame_length = frame_count;
            frame_mode     = MODE_HUNT;
        end
        else
        begin
            r.event_res  = EV_DATA;
            r.data_byte  = b;
            r.byte_index = frame_count[7:0];
            frame_count  = frame_count + 9'd1;
            frame_mode   = MODE_FRAME;
        end
        return r;
    endfunction

    // Advance the shadow framing state by one byte and return the event it raises.
    function automatic res_t deframe_byte(input logic [7:0] b);
        res_t r;
        r = '0;
        case (frame_mode)
            MODE_HUNT:
            begin
                if (b == SYM_DLE)
                    frame_mode = MODE_HUNT_DLE;
            end
            MODE_HUNT_DLE:
            begin
                // Repeated DLEs keep the start pair open.
                if (b == SYM_STX)
                begin
                    frame_mode  = MODE_FRAME;
                    frame_count = '0;
                end
                else if (b != SYM_DLE)
                    frame_mode = MODE_HUNT;
            end
            MODE_FRAME:
            begin
                if (b == SYM_DLE)
                    frame_mode = MODE_FRAME_ESC;
                else
                    r = store_data(b);
            end
            default:
            begin
                if (b == SYM_DLE)
                    r = store_data(b);
                else if (b == SYM_ETX)
                begin
                    r.event_res    = EV_END_OK;
                    r.frame_length = frame_count;
                    frame_mode     = MODE_HUNT;
                end
                else
                begin
                    // Bad escape: the byte is eaten, not taken as a new start.
                    r.event_res    = EV_BAD_ESC;
                    r.frame_length = frame_count;
                    frame_mode     = MODE_HUNT;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Offer one byte, hold it until the transfer, then queue its expected event.
    task automatic send_byte(input logic [7:0] b, input bit typed, input res_t typed_res);
        res_t r;
        while (!quiet_run && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = deframe_byte(b);
        pending_events.push_back(typed ? typed_res : r);
        bytes_sent++;
        // Run one stretch with no idling on either side.
        quiet_run = (bytes_sent >= 500 && bytes_sent < 650);
    endtask

    // Write the length limit only once the pipeline has drained.
    task automatic write_cap(input logic [8:0] cap);
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES + 2) @(posedge clk);
        cfg_valid  <= 1'b1;
        max_length <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        length_cap = cap;
    endtask

    // Emit one frame with random stuffed payload; some frames are broken on purpose.
    task automatic send_frame(input int len);
        int         pick;
        logic [7:0] b;
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        send_byte(SYM_DLE, 1'b0, '0);
        if ($urandom_range(0, 4) == 0)
            send_byte(SYM_DLE, 1'b0, '0);
        send_byte(SYM_STX, 1'b0, '0);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 7);
            case (pick)
                0:       b = SYM_DLE;
                1:       b = SYM_STX;
                2:       b = SYM_ETX;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, 1'b0, '0);
            if (b == SYM_DLE)
                send_byte(SYM_DLE, 1'b0, '0);
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            // Broken escape at the end of the frame.
            do
                b = 8'($urandom_range(0, 255));
            while (b == SYM_DLE || b == SYM_ETX);
            send_byte(SYM_DLE, 1'b0, '0);
            send_byte(b, 1'b0, '0);
        end
        else if (pick != 1)
        begin
            send_byte(SYM_DLE, 1'b0, '0);
            send_byte(SYM_ETX, 1'b0, '0);
        end
        // pick == 1: drop the trailer, the next start pair lands inside the frame.
    endtask

    // One limit setting: an optional long frame to force overflow, then short frames.
    task automatic run_phase(input logic [8:0] cap, input int quota, input int long_len);
        int first_sent;
        int top;
        write_cap(cap);
        first_sent = bytes_sent;
        if (long_len > 0)
            send_frame(long_len);
        while (bytes_sent - first_sent < quota)
        begin
            top = (cap_limit() < 20) ? int'(cap_limit()) + 2 : 24;
            send_frame($urandom_range(0, top));
        end
    endtask

    function automatic stim_row_t mk_row(input row_kind_t kind, input logic [8:0] value,
                                         input bit typed, input ev_t ev,
                                         input logic [7:0] data, input logic [7:0] idx,
                                         input logic [8:0] len);
        stim_row_t row;
        row.kind              = kind;
        row.value             = value;
        row.typed             = typed;
        row.want              = '0;
        row.want.event_res    = ev;
        row.want.data_byte    = data;
        row.want.byte_index   = idx;
        row.want.frame_length = len;
        return row;
    endfunction

    // Result side: check every transfer against the oldest expectation, stall at random.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
                report_mismatch("result with nothing pending, event", event_res, 0);
            else
            begin
                head_event = pending_events.pop_front();
                if (event_res !== head_event.event_res)
                    report_mismatch("event_res", event_res, head_event.event_res);
                if (data_byte !== head_event.data_byte)
                    report_mismatch("data_byte", data_byte, head_event.data_byte);
                if (byte_index !== head_event.byte_index)
                    report_mismatch("byte_index", byte_index, head_event.byte_index);
                if (frame_length !== head_event.frame_length)
                    report_mismatch("frame_length", frame_length, head_event.frame_length);
            end
        end
        out_stall <= (!quiet_run && $urandom_range(0, 99) < IDLE_PCT);
    end

    initial
    begin
        // Hunting, repeated DLE before STX, stuffing, bare ETX as data, clean end.
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h000, 1'b1, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h010, 1'b1, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h010, 1'b1, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h002, 1'b1, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h000, 1'b1, EV_DATA, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h0FF, 1'b1, EV_DATA, 8'hFF, 8'h01, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h010, 1'b1, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h010, 1'b1, EV_DATA, 8'h10, 8'h02, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h003, 1'b1, EV_DATA, 8'h03, 8'h03, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h010, 1'b1, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h003, 1'b1, EV_END_OK, 8'h00, 8'h00, 9'd4));
        // Bad escape on an empty frame; the STX right after it must not restart.
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h010, 1'b1, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h002, 1'b1, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h010, 1'b1, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h055, 1'b1, EV_BAD_ESC, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h002, 1'b1, EV_NONE, 8'h00, 8'h00, 9'd0));
        // Limit of zero acts as one: the unstuffed DLE overflows the frame.
        stim_rows.push_back(mk_row(ROW_CFG, 9'h000, 1'b0, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h010, 1'b1, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h002, 1'b1, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h0AA, 1'b1, EV_DATA, 8'hAA, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h010, 1'b1, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h010, 1'b1, EV_OVERFLOW, 8'h00, 8'h00, 9'd1));
        // Fresh frame right after the overflow, checked by the shadow state only.
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h010, 1'b0, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h002, 1'b0, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h05A, 1'b0, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h010, 1'b0, EV_NONE, 8'h00, 8'h00, 9'd0));
        stim_rows.push_back(mk_row(ROW_BYTE, 9'h003, 1'b0, EV_NONE, 8'h00, 8'h00, 9'd0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_CFG)
                write_cap(stim_rows[i].value);
            else
                send_byte(stim_rows[i].value[7:0], stim_rows[i].typed, stim_rows[i].want);
        end

        // Random traffic across limit settings, extremes among them; the long frames
        // push past the clamped limit of the build size.
        run_phase(9'd1, 90, 0);
        run_phase(9'd511, 300, 258);
        run_phase(9'd2, 80, 0);
        run_phase(9'd256, 300, 257);
        run_phase(9'd3, 50, 0);
        run_phase(9'($urandom_range(4, 40)), 50, 0);
        run_phase(9'd300, 40, 0);
        run_phase(9'($urandom_range(1, 511)), 40, 0);
        run_phase(9'd0, 30, 0);

        // Drain the pipeline, then wait for any stray result to show.
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES + 6) @(posedge clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/dsed_pkg.sv
rtl/dsed_in_stage.sv
rtl/dsed_decode.sv
rtl/dsed_out_stage.sv
rtl/dle_stx_etx_deframer_core.sv
sim/tb_dle_stx_etx_deframer_core.sv
